@@ design/grpe_pkg.sv @@
package grpe_pkg;

  // Fixed field widths
  localparam int ROW_BITS   = 16;
  localparam int COLOR_W    = 16;
  localparam int GW_W       = 5;
  localparam int GH_W       = 6;
  localparam int CODE_W     = 8;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Default sizing
  localparam int DEF_MAX_GLYPH_WIDTH  = 16;
  localparam int DEF_MAX_GLYPH_HEIGHT = 32;
  localparam int DEF_CODE_COUNT       = 256;

  // Register reset values
  localparam logic [COLOR_W-1:0] FG_RESET = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_RESET = 16'h0000;
  localparam logic [GW_W-1:0]    GW_RESET = 5'd8;
  localparam logic [GH_W-1:0]    GH_RESET = 6'd16;

  // Register index (paddr word select)
  typedef enum logic [1:0] {
    REG_FG_COLOR     = 2'd0,
    REG_BG_COLOR     = 2'd1,
    REG_GLYPH_WIDTH  = 2'd2,
    REG_GLYPH_HEIGHT = 2'd3
  } reg_idx_t;

  // Input operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Glyph row handed from the read stage to the expander
  typedef struct packed {
    logic [ROW_BITS-1:0] bits;
    logic [GW_W-1:0]     width;
  } glyph_beat_t;

endpackage

@@ design/grpe_ram.sv @@
module grpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single write port, registered read that holds when not enabled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/grpe_expander.sv @@
module grpe_expander (
  input  logic                             clk,
  input  logic                             rst_n,
  // glyph row beat from the read stage
  input  logic                             row_valid,
  input  grpe_pkg::glyph_beat_t            row_beat,
  output logic                             row_take,
  // colours
  input  logic [grpe_pkg::COLOR_W-1:0]     fg_color,
  input  logic [grpe_pkg::COLOR_W-1:0]     bg_color,
  // pixel beats
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [grpe_pkg::COLOR_W-1:0]     out_pixel_color,
  output logic [grpe_pkg::COL_W-1:0]       out_column,
  output logic                             out_ink,
  output logic                             out_last
);

  // Shift stage
  logic                            sh_valid_r, sh_valid_nxt;
  logic [grpe_pkg::ROW_BITS-1:0]   sh_bits_r, sh_bits_nxt;
  logic [grpe_pkg::GW_W-1:0]       sh_width_r, sh_width_nxt;
  logic [grpe_pkg::COL_W-1:0]      sh_col_r, sh_col_nxt;

  // Output register
  logic                            o_valid_r, o_valid_nxt;
  logic [grpe_pkg::COLOR_W-1:0]    o_color_r, o_color_nxt;
  logic [grpe_pkg::COL_W-1:0]      o_col_r, o_col_nxt;
  logic                            o_ink_r, o_ink_nxt;
  logic                            o_last_r, o_last_nxt;

  logic o_free;
  logic emit;
  logic sh_last;
  logic sh_free;
  logic ink_bit;

  assign o_free  = !o_valid_r || !out_stall;
  assign emit    = sh_valid_r && o_free;
  assign sh_last = ({1'b0, sh_col_r} + 5'd1) == sh_width_r;
  assign sh_free = !sh_valid_r || (emit && sh_last);
  assign ink_bit = sh_bits_r[grpe_pkg::ROW_BITS-1];

  assign row_take = row_valid && sh_free;

  // Next state for shift stage and output register
  always_comb begin
    sh_valid_nxt = sh_valid_r;
    sh_bits_nxt  = sh_bits_r;
    sh_width_nxt = sh_width_r;
    sh_col_nxt   = sh_col_r;
    o_valid_nxt  = o_valid_r;
    o_color_nxt  = o_color_r;
    o_col_nxt    = o_col_r;
    o_ink_nxt    = o_ink_r;
    o_last_nxt   = o_last_r;

    if (o_free) begin
      o_valid_nxt = emit;
    end
    if (emit) begin
      o_color_nxt = ink_bit ? fg_color : bg_color;
      o_col_nxt   = sh_col_r;
      o_ink_nxt   = ink_bit;
      o_last_nxt  = sh_last;
      sh_bits_nxt = {sh_bits_r[grpe_pkg::ROW_BITS-2:0], 1'b0};
      sh_col_nxt  = sh_col_r + 4'd1;
      if (sh_last) begin
        sh_valid_nxt = 1'b0;
      end
    end
    if (row_take) begin
      sh_valid_nxt = 1'b1;
      sh_bits_nxt  = row_beat.bits;
      sh_width_nxt = row_beat.width;
      sh_col_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      sh_valid_r <= sh_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
    sh_bits_r  <= sh_bits_nxt;
    sh_width_r <= sh_width_nxt;
    sh_col_r   <= sh_col_nxt;
    o_color_r  <= o_color_nxt;
    o_col_r    <= o_col_nxt;
    o_ink_r    <= o_ink_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid       = o_valid_r;
  assign out_pixel_color = o_color_r;
  assign out_column      = o_col_r;
  assign out_ink         = o_ink_r;
  assign out_last        = o_last_r;

endmodule

@@ design/glyph_row_pixel_expander_core.sv @@
// Text-mode character generator.
// Input channel (in_valid/in_stall): one beat per load or render item.
//   A load (in_op = 0) writes in_row_bits into the glyph store for
//   in_code/in_row and marks the code known; it gives no pixels.
//   A render (in_op = 1) emits one pixel beat per glyph column, leftmost
//   first, on the output channel (out_valid/out_stall); out_last flags the
//   final pixel. Unknown codes come out as background with ink clear.
// Path: the first pixel of a render passes the read stage, the shift stage and
//   the output register in turn.
// Throughput: one pixel per cycle while out_stall is low. A render holds the
//   shift stage until its last column is out. New items, loads included, keep
//   entering while earlier rows drain, until a render waits in the read stage.
// Stall: out_stall freezes the output register and backs up the pipeline
//   to in_stall; nothing is dropped or repeated.
// Reset: clears all pipeline valids and the code-known marks and sets the
//   registers to their defaults; glyph rows are undefined until loaded.
// Configuration: APB-style port, registers at byte 0, 4, 8, 12; write only
//   while the block is idle.
module glyph_row_pixel_expander_core #(
  parameter int MAX_GLYPH_WIDTH  = grpe_pkg::DEF_MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = grpe_pkg::DEF_MAX_GLYPH_HEIGHT,
  parameter int CODE_COUNT       = grpe_pkg::DEF_CODE_COUNT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [grpe_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [grpe_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [grpe_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [grpe_pkg::CODE_W-1:0]         in_code,
  input  logic [grpe_pkg::ROW_W-1:0]          in_row,
  input  logic [grpe_pkg::ROW_BITS-1:0]       in_row_bits,
  // pixel results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [grpe_pkg::COLOR_W-1:0]        out_pixel_color,
  output logic [grpe_pkg::COL_W-1:0]          out_column,
  output logic                                out_ink,
  output logic                                out_last
);

  // Only codes reachable through the 8-bit field need storage
  localparam int CODE_SPAN   = 1 << grpe_pkg::CODE_W;
  localparam int VALID_N     = (CODE_COUNT < CODE_SPAN) ? CODE_COUNT : CODE_SPAN;
  localparam int VIW         = $clog2(VALID_N);
  localparam int RAM_DEPTH   = VALID_N * MAX_GLYPH_HEIGHT;
  localparam int AW          = $clog2(RAM_DEPTH);
  localparam int WIDTH_CAP   = (MAX_GLYPH_WIDTH < grpe_pkg::ROW_BITS) ?
                               MAX_GLYPH_WIDTH : grpe_pkg::ROW_BITS;

  // Configuration registers
  logic [grpe_pkg::COLOR_W-1:0] fg_color_r;
  logic [grpe_pkg::COLOR_W-1:0] bg_color_r;
  logic [grpe_pkg::GW_W-1:0]    glyph_width_r;
  logic [grpe_pkg::GH_W-1:0]    glyph_height_r;
  logic                         cfg_wr;
  grpe_pkg::reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = grpe_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r     <= grpe_pkg::FG_RESET;
      bg_color_r     <= grpe_pkg::BG_RESET;
      glyph_width_r  <= grpe_pkg::GW_RESET;
      glyph_height_r <= grpe_pkg::GH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        grpe_pkg::REG_FG_COLOR:     fg_color_r     <= pwdata[grpe_pkg::COLOR_W-1:0];
        grpe_pkg::REG_BG_COLOR:     bg_color_r     <= pwdata[grpe_pkg::COLOR_W-1:0];
        grpe_pkg::REG_GLYPH_WIDTH:  glyph_width_r  <= pwdata[grpe_pkg::GW_W-1:0];
        grpe_pkg::REG_GLYPH_HEIGHT: glyph_height_r <= pwdata[grpe_pkg::GH_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      grpe_pkg::REG_FG_COLOR:     prdata = 32'(fg_color_r);
      grpe_pkg::REG_BG_COLOR:     prdata = 32'(bg_color_r);
      grpe_pkg::REG_GLYPH_WIDTH:  prdata = 32'(glyph_width_r);
      grpe_pkg::REG_GLYPH_HEIGHT: prdata = 32'(glyph_height_r);
      default:                    prdata = '0;
    endcase
  end

  // Input decode
  logic                           in_acc;
  logic                           code_ok;
  logic                           row_ok;
  logic                           row_shown;
  logic [VIW-1:0]                 code_idx;
  logic [31:0]                    addr_full;
  logic [AW-1:0]                  ram_addr;
  logic [grpe_pkg::GW_W-1:0]      width_eff;
  logic                           do_load;
  logic                           do_render;

  assign in_acc    = in_valid && !in_stall;
  assign code_ok   = {1'b0, in_code} < 9'(VALID_N);
  assign row_ok    = {2'b0, in_row} < 7'(MAX_GLYPH_HEIGHT);
  assign row_shown = row_ok && ({1'b0, in_row} < glyph_height_r);
  assign code_idx  = in_code[VIW-1:0];
  assign addr_full = 32'(code_idx) * 32'(MAX_GLYPH_HEIGHT) + 32'(in_row);
  assign ram_addr  = addr_full[AW-1:0];
  assign width_eff = (glyph_width_r > 5'(WIDTH_CAP)) ? 5'(WIDTH_CAP) : glyph_width_r;
  assign do_load   = in_acc && (in_op == grpe_pkg::OP_LOAD) && code_ok && row_ok;
  assign do_render = in_acc && (in_op == grpe_pkg::OP_RENDER) && row_shown &&
                     (width_eff != '0);

  // Code-known marks
  logic [VALID_N-1:0] code_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_valid_r <= '0;
    end else if (do_load) begin
      code_valid_r[code_idx] <= 1'b1;
    end
  end

  // Glyph store: write on load, read on render
  logic [grpe_pkg::ROW_BITS-1:0] ram_rdata;

  grpe_ram #(
    .WIDTH (grpe_pkg::ROW_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_glyph_store (
    .clk     (clk),
    .wr_en   (do_load),
    .wr_addr (ram_addr),
    .wr_data (in_row_bits),
    .rd_en   (do_render),
    .rd_addr (ram_addr),
    .rd_data (ram_rdata)
  );

  // Read stage: waits on the store's registered read
  logic                      rd_valid_r, rd_valid_nxt;
  logic                      rd_known_r, rd_known_nxt;
  logic [grpe_pkg::GW_W-1:0] rd_width_r, rd_width_nxt;
  logic                      row_take;
  grpe_pkg::glyph_beat_t     row_beat;

  assign in_stall = rd_valid_r && !row_take;

  always_comb begin
    rd_valid_nxt = rd_valid_r;
    rd_known_nxt = rd_known_r;
    rd_width_nxt = rd_width_r;
    if (row_take) begin
      rd_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      rd_valid_nxt = do_render;
      rd_known_nxt = code_ok && code_valid_r[code_idx];
      rd_width_nxt = width_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_valid_nxt;
    end
    rd_known_r <= rd_known_nxt;
    rd_width_r <= rd_width_nxt;
  end

  // Unknown codes expand as an empty row
  assign row_beat.bits  = rd_known_r ? ram_rdata : '0;
  assign row_beat.width = rd_width_r;

  // Shift stage and output register
  grpe_expander u_expander (
    .clk             (clk),
    .rst_n           (rst_n),
    .row_valid       (rd_valid_r),
    .row_beat        (row_beat),
    .row_take        (row_take),
    .fg_color        (fg_color_r),
    .bg_color        (bg_color_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_color (out_pixel_color),
    .out_column      (out_column),
    .out_ink         (out_ink),
    .out_last        (out_last)
  );

endmodule

@@ sim/glyph_pixel_monitor.sv @@
// Watches the config port and both channels of the glyph expander, keeps its
// own copy of the glyph store and registers, and checks every pixel beat.
module glyph_pixel_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [grpe_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [grpe_pkg::CFG_DATA_W-1:0]     pwdata,
  input  logic                                pready,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_op,
  input  logic [grpe_pkg::CODE_W-1:0]         in_code,
  input  logic [grpe_pkg::ROW_W-1:0]          in_row,
  input  logic [grpe_pkg::ROW_BITS-1:0]       in_row_bits,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [grpe_pkg::COLOR_W-1:0]        out_pixel_color,
  input  logic [grpe_pkg::COL_W-1:0]          out_column,
  input  logic                                out_ink,
  input  logic                                out_last,
  output int unsigned                         fail_count,
  output int unsigned                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import grpe_pkg::*;

  localparam int CODES = DEF_CODE_COUNT;
  localparam int ROWS  = DEF_MAX_GLYPH_HEIGHT;
  localparam int MAX_W = DEF_MAX_GLYPH_WIDTH;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COL_W-1:0]   column;
    logic               ink;
    logic               last;
  } pixel_t;

  // shadow of the block
  logic [ROW_BITS-1:0] glyph_rows [CODES][ROWS];
  logic                code_known [CODES];
  logic [COLOR_W-1:0]  fg;
  logic [COLOR_W-1:0]  bg;
  logic [GW_W-1:0]     width;
  logic [GH_W-1:0]     height;

  pixel_t expected_pixels [$];

  initial fail_count = 0;
  initial pending = 0;

  // one render item turns into a row of pixels, leftmost first
  function automatic void expand_row(input logic [CODE_W-1:0] code,
                                     input logic [ROW_W-1:0] row);
    logic [ROW_BITS-1:0] glyph;
    int unsigned         span;
    pixel_t              pix;
    if ({1'b0, row} >= height) return;
    span = (width > MAX_W) ? MAX_W : width;
    if (span == 0) return;
    glyph = code_known[code] ? glyph_rows[code][row] : '0;
    for (int c = 0; c < span; c++) begin
      pix.ink    = glyph[ROW_BITS-1-c];
      pix.color  = pix.ink ? fg : bg;
      pix.column = 4'(c);
      pix.last   = (c + 1 == span);
      expected_pixels.push_back(pix);
    end
  endfunction

  task automatic compare_field(input string what, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      for (int k = 0; k < CODES; k++) code_known[k] = 1'b0;
      fg     = FG_RESET;
      bg     = BG_RESET;
      width  = GW_RESET;
      height = GH_RESET;
      expected_pixels.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FG_COLOR:     fg     = pwdata[COLOR_W-1:0];
          REG_BG_COLOR:     bg     = pwdata[COLOR_W-1:0];
          REG_GLYPH_WIDTH:  width  = pwdata[GW_W-1:0];
          REG_GLYPH_HEIGHT: height = pwdata[GH_W-1:0];
          default: ;
        endcase
      end

      // pixel beat out
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected pixel, expected none, got color %0h column %0d ink %b last %b",
                   $time, out_pixel_color, out_column, out_ink, out_last);
        end else begin
          want = expected_pixels.pop_front();
          compare_field("pixel_color", 32'(want.color), 32'(out_pixel_color));
          compare_field("column", 32'(want.column), 32'(out_column));
          compare_field("ink", 32'(want.ink), 32'(out_ink));
          compare_field("last", 32'(want.last), 32'(out_last));
        end
      end

      // item beat in
      if (in_valid && !in_stall) begin
        if (in_op == OP_LOAD) begin
          glyph_rows[in_code][in_row] = in_row_bits;
          code_known[in_code] = 1'b1;
        end else begin
          expand_row(in_code, in_row);
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import grpe_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid, in_stall, in_op;
  logic [CODE_W-1:0]     in_code;
  logic [ROW_W-1:0]      in_row;
  logic [ROW_BITS-1:0]   in_row_bits;
  logic                  out_valid, out_stall;
  logic [COLOR_W-1:0]    out_pixel_color;
  logic [COL_W-1:0]      out_column;
  logic                  out_ink, out_last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles = 0;

  // stimulus-side view of what has been loaded, so no unwritten row is read
  bit          row_written [256][32];
  bit          code_known [256];
  int unsigned cur_height = 32'(GH_RESET);
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;

  always #4 clk = ~clk;

  glyph_row_pixel_expander_core i_dut (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_op, .in_code, .in_row, .in_row_bits,
    .out_valid, .out_stall, .out_pixel_color, .out_column, .out_ink, .out_last
  );

  glyph_pixel_monitor i_monitor (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid, .in_stall, .in_op, .in_code, .in_row, .in_row_bits,
    .out_valid, .out_stall, .out_pixel_color, .out_column, .out_ink, .out_last,
    .fail_count, .pending
  );

  // watchdog: cycles without any beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // receiver: random stall stretches, one long hold on request
  initial begin
    int unsigned run_len, hold_len;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      run_len = ($urandom_range(9) == 0) ? $urandom_range(150, 50) : $urandom_range(8, 1);
      repeat (run_len) @(posedge clk);
      if (hold_req) begin
        hold_len = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        hold_len = idle_len();
      end
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic op, input logic [CODE_W-1:0] code,
                           input logic [ROW_W-1:0] row, input logic [ROW_BITS-1:0] bits);
    int unsigned gap;
    in_valid    <= 1'b1;
    in_op       <= op;
    in_code     <= code;
    in_row      <= row;
    in_row_bits <= bits;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) begin
      row_written[code][row] = 1'b1;
      code_known[code] = 1'b1;
    end
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every pixel is out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [15:0] fg, input logic [15:0] bg,
                           input logic [4:0] width, input logic [5:0] height);
    drain();
    reg_write(REG_FG_COLOR, 32'(fg));
    reg_write(REG_BG_COLOR, 32'(bg));
    reg_write(REG_GLYPH_WIDTH, 32'(width));
    reg_write(REG_GLYPH_HEIGHT, 32'(height));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_height = 32'(height);
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_color();
    int unsigned p;
    p = $urandom_range(9);
    if (p == 0) return 16'h0000;
    if (p == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic random_config();
    logic [4:0]  w;
    logic [5:0]  h;
    int unsigned p;
    p = $urandom_range(99);
    if (p < 10)      w = 5'd0;
    else if (p < 22) w = 5'd16;
    else if (p < 32) w = 5'($urandom_range(31, 17));
    else             w = 5'($urandom_range(15, 1));
    p = $urandom_range(99);
    if (p < 5)       h = 6'd0;
    else if (p < 15) h = 6'($urandom_range(63, 33));
    else if (p < 30) h = 6'd32;
    else             h = 6'($urandom_range(31, 1));
    configure(pick_color(), pick_color(), w, h);
  endtask

  // loads mostly into a small pool of codes; renders only read rows already
  // loaded for a known code, anything goes for an unknown one
  task automatic random_item();
    int unsigned     p, lim, n;
    logic [CODE_W-1:0] c;
    logic [ROW_W-1:0]  r;
    logic [ROW_W-1:0]  rows_avail [32];
    p = $urandom_range(99);
    if (p < 35) begin
      c = 8'((p < 25) ? $urandom_range(15) : $urandom);
      lim = (cur_height > 32) ? 32 : cur_height;
      r = 5'(($urandom_range(4) != 0 && lim != 0) ? $urandom_range(lim - 1) : $urandom);
      send_item(OP_LOAD, c, r, 16'($urandom));
    end else begin
      c = 8'((p < 80) ? $urandom_range(15) : $urandom);
      if (code_known[c]) begin
        n = 0;
        for (int k = 0; k < 32; k++) begin
          if (row_written[c][k]) begin
            rows_avail[n] = 5'(k);
            n++;
          end
        end
        r = rows_avail[$urandom_range(n - 1)];
      end else begin
        r = 5'($urandom);
      end
      send_item(OP_RENDER, c, r, 16'($urandom));
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    in_op       <= OP_LOAD;
    in_code     <= '0;
    in_row      <= '0;
    in_row_bits <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, all-set and all-clear rows, load above height
    send_item(OP_LOAD, 8'h00, 5'd0, 16'hFFFF);
    send_item(OP_LOAD, 8'hFF, 5'd15, 16'h0000);
    send_item(OP_LOAD, 8'h55, 5'd31, 16'h8001);
    send_item(OP_LOAD, 8'hAA, 5'd1, 16'hAAAA);
    send_item(OP_LOAD, 8'h55, 5'd0, 16'h5555);
    send_item(OP_RENDER, 8'h00, 5'd0, 16'h0000);
    send_item(OP_RENDER, 8'hFF, 5'd15, 16'hFFFF);
    send_item(OP_RENDER, 8'hAA, 5'd1, 16'h0000);
    send_item(OP_RENDER, 8'h80, 5'd5, 16'h0000);  // never loaded
    send_item(OP_RENDER, 8'h55, 5'd31, 16'h0000); // row past height
    send_item(OP_RENDER, 8'h55, 5'd0, 16'h0000);

    // full width and height, colours swapped
    configure(16'h0000, 16'hFFFF, 5'd16, 6'd32);
    send_item(OP_RENDER, 8'h55, 5'd31, 16'h0000);
    send_item(OP_RENDER, 8'hAA, 5'd1, 16'h0000);
    send_item(OP_RENDER, 8'h7F, 5'd31, 16'h0000);

    // smallest glyph
    configure(16'hFFFF, 16'h0000, 5'd1, 6'd1);
    send_item(OP_RENDER, 8'h00, 5'd0, 16'h0000);
    send_item(OP_RENDER, 8'hFF, 5'd15, 16'h0000);

    // zero width renders nothing
    configure(16'hFFFF, 16'h0000, 5'd0, 6'd1);
    send_item(OP_RENDER, 8'h00, 5'd0, 16'h0000);
    send_item(OP_LOAD, 8'h01, 5'd2, 16'h1234);

    // widths above the maximum saturate
    configure(16'h1234, 16'hEDCB, 5'd31, 6'd63);
    send_item(OP_RENDER, 8'h55, 5'd0, 16'h0000);
    send_item(OP_RENDER, 8'h01, 5'd2, 16'h0000);
    configure(16'h1234, 16'hEDCB, 5'd17, 6'd63);
    send_item(OP_RENDER, 8'hAA, 5'd1, 16'h0000);

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 1) begin
        // backpressure: receiver holds off while the sender keeps going
        configure(pick_color(), pick_color(), 5'd16, 6'd32);
        steady = 1'b1;
        hold_req = 1'b1;
        wait (!hold_req);
        for (int i = 0; i < 24; i++) random_item();
        steady = 1'b0;
      end else begin
        random_config();
        steady = (ph == 3);
        for (int i = 0; i < 14; i++) begin
          if (ph == 4 && i == 9) drain();
          random_item();
        end
        steady = 1'b0;
      end
    end

    drain();
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
design/grpe_pkg.sv
design/grpe_ram.sv
design/grpe_expander.sv
design/glyph_row_pixel_expander_core.sv
sim/glyph_pixel_monitor.sv
sim/tb.sv
